[hw/rtl/http_byte_range_parser_unit_assert.svh]
// Assertion macros used by the byte-range parser RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef HTTP_BYTE_RANGE_PARSER_UNIT_ASSERT_SVH
`define HTTP_BYTE_RANGE_PARSER_UNIT_ASSERT_SVH

// The antecedent holds, so the consequent must hold in the same cycle.
`define HBRP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent holds, so the consequent must hold in the next cycle.
`define HBRP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/hbrp_pkg.sv]
// ----------------------------------------------------------------------------
// hbrp_pkg
// Types, codes and character constants of the byte-range parser.
// ----------------------------------------------------------------------------
package hbrp_pkg;

	localparam int BYTE_W   = 8;
	localparam int VAL_W    = 64;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PARSE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNIT  = 2'd2;

	// Number scanner phases.
	localparam logic [1:0] PH_BLANK  = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_STOP   = 2'd3;

	// How a closed spec turns into offsets.
	localparam logic [1:0] MODE_SUFFIX = 2'd0;
	localparam logic [1:0] MODE_OPEN   = 2'd1;
	localparam logic [1:0] MODE_FULL   = 2'd2;

	localparam logic [BYTE_W-1:0] CH_EQUALS = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5A;
	localparam logic [BYTE_W-1:0] CASE_OFS  = 8'h20;

	localparam logic [CNT_W-1:0] UNIT_LEN = 3'd5;

	typedef struct packed {
		logic [1:0]       phase;
		logic             neg;
		logic [VAL_W-1:0] val;
		logic             bad;
	} num_t;

	typedef struct packed {
		logic has_dash;
		logic lead;
		logic after;
		num_t first;
		num_t second;
	} spec_t;

	// Characters of the only supported unit, lower case.
	function automatic logic [BYTE_W-1:0] unit_char(input logic [CNT_W-1:0] idx);
		logic [BYTE_W-1:0] ch;
		unique case (idx)
			3'd0:    ch = 8'h62;
			3'd1:    ch = 8'h79;
			3'd2:    ch = 8'h74;
			3'd3:    ch = 8'h65;
			3'd4:    ch = 8'h73;
			default: ch = '0;
		endcase
		return ch;
	endfunction

endpackage

[hw/rtl/hbrp_in_if.sv]
// ----------------------------------------------------------------------------
// hbrp_in_if
// Header channel: one header character per word, with the object size.
// ----------------------------------------------------------------------------
interface hbrp_in_if;
	import hbrp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] header_byte;
	logic              header_end;
	logic [VAL_W-1:0]  object_size;

	modport source (output valid, header_byte, header_end, object_size, input ready);
	modport sink   (input valid, header_byte, header_end, object_size, output ready);
endinterface

[hw/rtl/hbrp_out_if.sv]
// ----------------------------------------------------------------------------
// hbrp_out_if
// Result channel: one parsed range or error per word.
// ----------------------------------------------------------------------------
interface hbrp_out_if;
	import hbrp_pkg::*;

	logic                valid;
	logic                ready;
	logic [VAL_W-1:0]    range_start;
	logic [VAL_W-1:0]    range_end;
	logic [STATUS_W-1:0] status;
	logic                last_result;

	modport source (output valid, range_start, range_end, status, last_result, input ready);
	modport sink   (input valid, range_start, range_end, status, last_result, output ready);
endinterface

[hw/rtl/http_byte_range_parser_unit.sv]
// ----------------------------------------------------------------------------
// http_byte_range_parser_unit
// Streaming parser for an HTTP Range header, one character per word.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Word carries
//   --------+-----------+-------------------------------------------------
//   hdr     | in        | header_byte, header_end, object_size
//   rng     | out       | range_start, range_end, status, last_result
//
// One header character is taken every clock cycle while hdr.ready is high. A
// closing character's result is registered in the first stage (parser state
// update), then in the output register (offset arithmetic). The parser state
// loop is the only serial path, so words may arrive back to back.
// arst_n clears the parser state and both pipeline stages at once.
// When rng stalls, the two stages hold and hdr.ready drops only once both are
// full; characters that produce no result still need a free first stage.
//
`include "http_byte_range_parser_unit_assert.svh"

module http_byte_range_parser_unit (
	input  logic             clk,
	input  logic             arst_n,
	hbrp_in_if.sink          hdr,
	hbrp_out_if.source       rng
);
	import hbrp_pkg::*;

	// ------------------------------------------------------------------
	// Parser state. Before the '=' we match the unit text; after it we
	// track the current spec: whether it has a dash, and a small number
	// scanner for each side of the dash.
	// ------------------------------------------------------------------
	logic             seen_eq_q;
	logic [CNT_W-1:0] unit_cnt_q;
	logic             unit_bad_q;
	logic             discard_q;
	spec_t            spec_q;

	// First stage: status decided, operands captured for the arithmetic.
	logic                s1_valid_q;
	logic [STATUS_W-1:0] status_s1;
	logic                last_s1;
	logic [1:0]          mode_s1;
	num_t                first_s1;
	num_t                second_s1;
	logic [VAL_W-1:0]    size_s1;

	// Second stage is the output register.
	logic                out_valid_q;
	logic [VAL_W-1:0]    start_s2;
	logic [VAL_W-1:0]    end_s2;
	logic [STATUS_W-1:0] status_s2;
	logic                last_s2;

	logic adv2;
	logic accept;

	// Next-state values.
	logic             seen_eq_nx;
	logic [CNT_W-1:0] unit_cnt_nx;
	logic             unit_bad_nx;
	logic             discard_nx;
	spec_t            spec_nx;
	spec_t            spec_upd;
	spec_t            snap;
	logic             emit;
	logic [STATUS_W-1:0] st;
	logic             last;
	logic [BYTE_W-1:0] lc;

	logic [VAL_W-1:0] a_val;
	logic [VAL_W-1:0] sfx_start;
	logic [VAL_W-1:0] full_end;
	logic [VAL_W-1:0] start_c;
	logic [VAL_W-1:0] end_c;

	// ------------------------------------------------------------------
	// Number scanner, following strtoull: blanks, an optional sign, then
	// digits. The first non-digit stops it. Overflow and a missing digit
	// both raise the bad flag.
	// ------------------------------------------------------------------
	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic num_t num_feed(input num_t n, input logic [BYTE_W-1:0] c);
		num_t              r;
		logic              digit;
		logic [VAL_W+3:0]  ext;
		logic [VAL_W+3:0]  prod;
		r     = n;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		ext   = {4'b0000, n.val};
		// val*10 + digit, four guard bits show the overflow.
		prod  = (ext << 3) + (ext << 1) + {{VAL_W{1'b0}}, c[3:0]};
		unique case (n.phase)
			PH_BLANK: begin
				if (is_blank(c)) begin
					r.phase = PH_BLANK;
				end else if (c == CH_PLUS) begin
					r.phase = PH_SIGN;
				end else if (c == CH_DASH) begin
					r.neg   = 1'b1;
					r.phase = PH_SIGN;
				end else if (!digit) begin
					r.bad   = 1'b1;
					r.phase = PH_STOP;
				end else begin
					r.phase = PH_DIGITS;
				end
			end
			PH_SIGN: begin
				if (digit) begin
					r.phase = PH_DIGITS;
				end else begin
					r.bad   = 1'b1;
					r.phase = PH_STOP;
				end
			end
			PH_DIGITS: begin
				if (!digit) begin
					r.phase = PH_STOP;
				end
			end
			PH_STOP: begin
				r.phase = PH_STOP;
			end
		endcase
		if (digit && !n.bad && (n.phase != PH_STOP) &&
		    !(n.phase == PH_BLANK && 1'b0)) begin
			if (n.phase == PH_BLANK || n.phase == PH_SIGN || n.phase == PH_DIGITS) begin
				if (|prod[VAL_W+3:VAL_W]) begin
					r.bad = 1'b1;
				end else begin
					r.val = prod[VAL_W-1:0];
				end
			end
		end
		return r;
	endfunction

	function automatic logic num_ok(input num_t n);
		return (n.phase == PH_DIGITS || n.phase == PH_STOP) && !n.bad;
	endfunction

	// Status of a spec as it closes; needs only flags, no arithmetic.
	function automatic logic [STATUS_W-1:0] close_status(input spec_t s);
		logic ok;
		if (!s.has_dash) begin
			ok = 1'b0;
		end else if (!s.lead) begin
			ok = num_ok(s.second);
		end else if (!s.after) begin
			ok = num_ok(s.first);
		end else begin
			ok = num_ok(s.first) && num_ok(s.second);
		end
		return ok ? ST_OK : ST_PARSE;
	endfunction

	function automatic logic [1:0] close_mode(input spec_t s);
		logic [1:0] m;
		if (!s.lead) begin
			m = MODE_SUFFIX;
		end else if (!s.after) begin
			m = MODE_OPEN;
		end else begin
			m = MODE_FULL;
		end
		return m;
	endfunction

	// ------------------------------------------------------------------
	// Handshake. The output register frees up when it is empty or taken;
	// the first stage moves whenever the output register can take it.
	// ------------------------------------------------------------------
	assign adv2      = !out_valid_q || rng.ready;
	assign hdr.ready = !s1_valid_q || adv2;
	assign accept    = hdr.valid && hdr.ready;

	// The current spec with this character fed to the proper side.
	always_comb begin
		spec_upd = spec_q;
		if (!spec_q.has_dash) begin
			if (hdr.header_byte == CH_DASH) begin
				spec_upd.has_dash = 1'b1;
			end else begin
				spec_upd.lead  = 1'b1;
				spec_upd.first = num_feed(spec_q.first, hdr.header_byte);
			end
		end else begin
			spec_upd.after  = 1'b1;
			spec_upd.second = num_feed(spec_q.second, hdr.header_byte);
		end
	end

	// Per-character control: unit check, spec split, result decision.
	always_comb begin
		seen_eq_nx  = seen_eq_q;
		unit_cnt_nx = unit_cnt_q;
		unit_bad_nx = unit_bad_q;
		discard_nx  = discard_q;
		spec_nx     = spec_q;
		snap        = spec_q;
		emit        = 1'b0;
		st          = ST_OK;
		last        = 1'b0;
		lc          = hdr.header_byte;
		if (hdr.header_byte >= CH_UP_A && hdr.header_byte <= CH_UP_Z) begin
			lc = hdr.header_byte + CASE_OFS;
		end

		if (discard_q) begin
			// After an error, wait quietly for the end of the header.
			emit = 1'b0;
		end else if (!seen_eq_q) begin
			if (hdr.header_byte == CH_EQUALS) begin
				if (unit_bad_q || unit_cnt_q != UNIT_LEN) begin
					emit = 1'b1;
					st   = ST_UNIT;
					last = 1'b1;
				end else begin
					seen_eq_nx = 1'b1;
					if (hdr.header_end) begin
						// Nothing after the equals sign: one empty piece.
						emit = 1'b1;
						st   = ST_PARSE;
						last = 1'b1;
					end
				end
			end else begin
				if (unit_cnt_q < UNIT_LEN && lc == unit_char(unit_cnt_q)) begin
					unit_cnt_nx = unit_cnt_q + 3'd1;
				end else begin
					unit_bad_nx = 1'b1;
				end
				if (hdr.header_end) begin
					emit = 1'b1;
					st   = ST_PARSE;
					last = 1'b1;
				end
			end
		end else if (hdr.header_byte == CH_COMMA) begin
			emit = 1'b1;
			st   = close_status(spec_q);
			// A trailing comma leaves an empty final piece, which fails.
			if (hdr.header_end && st == ST_OK) begin
				st = ST_PARSE;
			end
			last    = hdr.header_end || (st != ST_OK);
			spec_nx = '0;
		end else begin
			spec_nx = spec_upd;
			snap    = spec_upd;
			if (hdr.header_end) begin
				emit = 1'b1;
				st   = close_status(spec_upd);
				last = 1'b1;
			end
		end

		if (hdr.header_end) begin
			seen_eq_nx  = 1'b0;
			unit_cnt_nx = '0;
			unit_bad_nx = 1'b0;
			discard_nx  = 1'b0;
			spec_nx     = '0;
		end else if (emit && last) begin
			discard_nx = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_eq_q  <= 1'b0;
			unit_cnt_q <= '0;
			unit_bad_q <= 1'b0;
			discard_q  <= 1'b0;
			spec_q     <= '0;
		end else if (accept) begin
			seen_eq_q  <= seen_eq_nx;
			unit_cnt_q <= unit_cnt_nx;
			unit_bad_q <= unit_bad_nx;
			discard_q  <= discard_nx;
			spec_q     <= spec_nx;
		end
	end

	// First stage: capture the decision and the operands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= emit;
		end else if (adv2) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			status_s1 <= st;
			last_s1   <= last;
			mode_s1   <= close_mode(snap);
			first_s1  <= snap.first;
			second_s1 <= snap.second;
			size_s1   <= hdr.object_size;
		end
	end

	// ------------------------------------------------------------------
	// Offset arithmetic. A minus sign negates modulo 2^64, so each form
	// folds the sign into one add or subtract.
	//   suffix  -N : start = size - N, end = size
	//   open    N- : start = N,        end = size
	//   full   A-B : start = A,        end = B + 1
	// ------------------------------------------------------------------
	always_comb begin
		a_val     = first_s1.neg ? (VAL_W'(0) - first_s1.val) : first_s1.val;
		sfx_start = second_s1.neg ? (size_s1 + second_s1.val) : (size_s1 - second_s1.val);
		full_end  = second_s1.neg ? (~second_s1.val + VAL_W'(2)) : (second_s1.val + VAL_W'(1));
		unique case (mode_s1)
			MODE_SUFFIX: begin
				start_c = sfx_start;
				end_c   = size_s1;
			end
			MODE_OPEN: begin
				start_c = a_val;
				end_c   = size_s1;
			end
			default: begin
				start_c = a_val;
				end_c   = full_end;
			end
		endcase
		if (status_s1 != ST_OK) begin
			start_c = '0;
			end_c   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv2) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && s1_valid_q) begin
			start_s2  <= start_c;
			end_s2    <= end_c;
			status_s2 <= status_s1;
			last_s2   <= last_s1;
		end
	end

	assign rng.valid       = out_valid_q;
	assign rng.range_start = start_s2;
	assign rng.range_end   = end_s2;
	assign rng.status      = status_s2;
	assign rng.last_result = last_s2;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	`HBRP_ASSERT_IMP(a_err_zero, rng.valid && rng.status != ST_OK,
		rng.range_start == '0 && rng.range_end == '0, "error result carries offsets")
	`HBRP_ASSERT_IMP(a_err_last, s1_valid_q && status_s1 != ST_OK, last_s1,
		"error result not marked last")
	`HBRP_ASSERT_IMP(a_unit_cnt, 1'b1, unit_cnt_q <= UNIT_LEN,
		"unit match count beyond unit length")
	`HBRP_ASSERT_NXT(a_s1_hold, s1_valid_q && !adv2,
		s1_valid_q && $stable(status_s1) && $stable(last_s1), "stalled first stage lost")

endmodule
